@@ rtl/bfdh_pkg.sv @@
// ----------------------------------------------------------------------------
// bfdh_pkg
// shared types, codes and defaults of the double hashing bloom filter
// ----------------------------------------------------------------------------
package bfdh_pkg;

	localparam int unsigned MAX_BITS_DEF   = 65536;
	localparam int unsigned MAX_PROBES_DEF = 16;

	localparam int unsigned CFG_W       = 17;
	localparam int unsigned NUM_BITS_W  = 17;
	localparam int unsigned NUM_HASH_W  = 5;
	localparam int unsigned NUM_BITS_RST = 65536;
	localparam int unsigned NUM_HASH_RST = 7;

	localparam logic CFG_NUM_BITS   = 1'b0;
	localparam logic CFG_NUM_HASHES = 1'b1;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] first_hash;
		logic [63:0] second_hash;
		logic [9:0]  word_index;
	} cmd_t;

	typedef struct packed {
		logic        maybe_present;
		logic [63:0] word_value;
		logic [31:0] insert_count;
	} res_t;

endpackage

@@ rtl/bfdh_mod.sv @@
// ----------------------------------------------------------------------------
// bfdh_mod
// 64-bit value modulo a run-time size, restoring, two quotient bits per cycle
// ----------------------------------------------------------------------------
module bfdh_mod #(
	parameter int unsigned SIZE_W = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [SIZE_W-1:0] rem
);

	logic [63:0]       dvd_q;
	logic [SIZE_W-1:0] div_q;
	logic [SIZE_W-1:0] rem_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SIZE_W:0]   r_a;
	logic [SIZE_W:0]   r_b;
	logic [SIZE_W-1:0] r_a_n;
	logic [SIZE_W-1:0] r_b_n;

	always_comb begin
		r_a = {rem_q, dvd_q[63]};
		if (r_a >= {1'b0, div_q}) begin
			r_a = r_a - {1'b0, div_q};
		end
		r_a_n = r_a[SIZE_W-1:0];
		r_b = {r_a_n, dvd_q[62]};
		if (r_b >= {1'b0, div_q}) begin
			r_b = r_b - {1'b0, div_q};
		end
		r_b_n = r_b[SIZE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[61:0], 2'b00};
			rem_q <= r_b_n;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ rtl/bloom_filter_double_hash_core.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_core
// bloom filter over a word memory, probe positions by double hashing
// ----------------------------------------------------------------------------
// channel  dir  signals                          transaction
// cmd      in   cmd_valid cmd_ready cmd          op, two hashes, word index
// res      out  res_valid res_ready res          present flag, word, count
// cfg      in   cfg_we cfg_index cfg_data        register write
//
// add/query: k probes, each one division in the shared 2-bit/cycle modulo
// unit, one memory read and a bit update (add) or bit test (query).
// read: one memory read. clear: MAX_BITS/64 words, one word per cycle.
// after reset a clearing pass over MAX_BITS/64 words runs before cmd_ready.
// one command at a time; a finished result waits in the res register.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_core #(
	parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
	parameter int unsigned MAX_PROBES = bfdh_pkg::MAX_PROBES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  bfdh_pkg::cmd_t            cmd,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bfdh_pkg::res_t            res,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bfdh_pkg::CFG_W-1:0] cfg_data
);

	localparam int unsigned WORDS    = MAX_BITS / 64;
	localparam int unsigned AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned SIZE_W   = $clog2(MAX_BITS) + 1;
	localparam int unsigned SIZE_TOP = (MAX_BITS / 64) * 64;
	localparam int unsigned PW       = $clog2(MAX_PROBES + 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_RDW  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]                      state_q;
	logic [bfdh_pkg::NUM_BITS_W-1:0] num_bits_q;
	logic [bfdh_pkg::NUM_HASH_W-1:0] num_hashes_q;
	logic [1:0]                      op_q;
	logic [63:0]                     v_q;
	logic [63:0]                     h2_q;
	logic [SIZE_W-1:0]               size_q;
	logic [PW-1:0]                   k_q;
	logic [PW-1:0]                   probe_q;
	logic [AW-1:0]                   waddr_q;
	logic [5:0]                      bitpos_q;
	logic                            present_q;
	logic                            rd_ok_q;
	logic [31:0]                     adds_q;
	logic [AW:0]                     clr_cnt_q;
	logic                            clr_op_q;
	logic                            res_valid_q;
	bfdh_pkg::res_t                  res_q;

	logic [63:0]       mem [WORDS];
	logic [63:0]       rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [63:0]       mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;

	logic              accept;
	logic [31:0]       size_raw;
	logic [31:0]       size_cl;
	logic [6:0]        k_raw;
	logic [6:0]        k_cl;
	logic [31:0]       widx_ext;
	logic              div_start;
	logic [63:0]       div_dvd;
	logic [SIZE_W-1:0] div_dsr;
	logic              div_done;
	logic [SIZE_W-1:0] div_rem;
	logic [63:0]       upd_word;
	logic              fin_go;

	assign accept    = cmd_valid && cmd_ready;
	assign cmd_ready = (state_q == S_IDLE);
	assign fin_go    = (state_q == S_FIN) && (!res_valid_q || res_ready);
	assign widx_ext  = {22'd0, cmd.word_index};

	// size and probe count clamps
	always_comb begin
		size_raw = {15'd0, num_bits_q[16:6], 6'd0};
		size_cl  = size_raw;
		if (size_raw < 32'd64) begin
			size_cl = 32'd64;
		end
		if (size_raw > 32'(MAX_BITS)) begin
			size_cl = 32'(SIZE_TOP);
		end
		k_raw = {2'd0, num_hashes_q};
		k_cl  = k_raw;
		if (k_raw < 7'd1) begin
			k_cl = 7'd1;
		end
		if (k_raw > 7'(MAX_PROBES)) begin
			k_cl = 7'(MAX_PROBES);
		end
	end

	always_comb begin
		upd_word = rd_q | (64'd1 << bitpos_q);
	end

	// modulo unit control
	always_comb begin
		div_start = 1'b0;
		div_dvd   = cmd.first_hash;
		div_dsr   = size_cl[SIZE_W-1:0];
		if (accept && (cmd.op == bfdh_pkg::OP_ADD || cmd.op == bfdh_pkg::OP_QUERY)) begin
			div_start = 1'b1;
		end
		if (state_q == S_UPD && (32'(probe_q) + 32'd1) != 32'(k_q)) begin
			div_start = 1'b1;
			div_dvd   = v_q + h2_q;
			div_dsr   = size_q;
		end
	end

	bfdh_mod #(
		.SIZE_W(SIZE_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dsr),
		.done    (div_done),
		.rem     (div_rem)
	);

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = widx_ext[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = waddr_q;
		mem_wdata = upd_word;
		if (accept && cmd.op == bfdh_pkg::OP_READ) begin
			mem_re = 1'b1;
		end
		if (state_q == S_DIV && div_done) begin
			mem_re    = 1'b1;
			mem_raddr = div_rem[AW+5:6];
		end
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q[AW-1:0];
			mem_wdata = '0;
		end
		if (state_q == S_UPD && op_q == bfdh_pkg::OP_ADD) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bits_q   <= bfdh_pkg::NUM_BITS_W'(bfdh_pkg::NUM_BITS_RST);
			num_hashes_q <= bfdh_pkg::NUM_HASH_W'(bfdh_pkg::NUM_HASH_RST);
		end else if (cfg_we) begin
			if (cfg_index == bfdh_pkg::CFG_NUM_BITS) begin
				num_bits_q <= cfg_data[bfdh_pkg::NUM_BITS_W-1:0];
			end else begin
				num_hashes_q <= cfg_data[bfdh_pkg::NUM_HASH_W-1:0];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			clr_op_q    <= 1'b0;
			adds_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && !fin_go) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (32'(clr_cnt_q) == WORDS - 1) begin
						state_q <= clr_op_q ? S_FIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd.op)
							bfdh_pkg::OP_ADD, bfdh_pkg::OP_QUERY: state_q <= S_DIV;
							bfdh_pkg::OP_CLEAR: begin
								state_q   <= S_CLR;
								clr_cnt_q <= '0;
								clr_op_q  <= 1'b1;
								adds_q    <= '0;
							end
							default: state_q <= S_RDW;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if ((32'(probe_q) + 32'd1) == 32'(k_q)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_RDW: state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b1;
						if (op_q == bfdh_pkg::OP_ADD) begin
							adds_q <= adds_q + 32'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= cmd.op;
			v_q       <= cmd.first_hash;
			h2_q      <= cmd.second_hash;
			size_q    <= size_cl[SIZE_W-1:0];
			k_q       <= k_cl[PW-1:0];
			probe_q   <= '0;
			present_q <= 1'b1;
			rd_ok_q   <= (widx_ext < 32'(WORDS));
		end
		if (state_q == S_DIV && div_done) begin
			waddr_q  <= div_rem[AW+5:6];
			bitpos_q <= div_rem[5:0];
		end
		if (state_q == S_UPD) begin
			probe_q <= probe_q + 1'b1;
			v_q     <= v_q + h2_q;
			if (!rd_q[bitpos_q]) begin
				present_q <= 1'b0;
			end
		end
		if (fin_go) begin
			res_q.maybe_present <= (op_q == bfdh_pkg::OP_QUERY) && present_q;
			res_q.word_value    <= (op_q == bfdh_pkg::OP_READ && rd_ok_q) ? rd_q : 64'd0;
			res_q.insert_count  <= (op_q == bfdh_pkg::OP_ADD) ? adds_q + 32'd1 : adds_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("memory written while idle");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("modulo result outside probe wait");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (probe_q < k_q))
		else $error("probe counter past probe count");
`endif

endmodule

@@ test/bfdh_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfdh_checker
// watches the cmd and res channels of the bloom filter, keeps its own copy
// of the bit array and insert count, and compares each res transaction
// with the oldest predicted one
// ----------------------------------------------------------------------------
module bfdh_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  bfdh_pkg::cmd_t               cmd,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  bfdh_pkg::res_t               res,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [bfdh_pkg::CFG_W-1:0]   cfg_data,
	output int                           errors,
	output int                           pending
);

	localparam int unsigned WORDS = bfdh_pkg::MAX_BITS_DEF / 64;

	logic [63:0] filter_words [WORDS];
	logic [31:0] add_total;
	logic [bfdh_pkg::NUM_BITS_W-1:0] size_reg;
	logic [bfdh_pkg::NUM_HASH_W-1:0] probe_reg;
	bfdh_pkg::res_t expected_q [$];

	function automatic logic [63:0] filter_size();
		logic [63:0] n;
		n = {47'd0, size_reg} & ~64'd63;
		if (n < 64) n = 64;
		if (n > bfdh_pkg::MAX_BITS_DEF) n = bfdh_pkg::MAX_BITS_DEF & ~64'd63;
		return n;
	endfunction

	function automatic int probe_count();
		int k;
		k = int'(probe_reg);
		if (k < 1) k = 1;
		if (k > bfdh_pkg::MAX_PROBES_DEF) k = bfdh_pkg::MAX_PROBES_DEF;
		return k;
	endfunction

	task automatic apply_cmd(input bfdh_pkg::cmd_t c);
		bfdh_pkg::res_t r;
		logic [63:0] sz, b, prod;
		int k;
		sz = filter_size();
		k = probe_count();
		r = '0;
		case (c.op)
			bfdh_pkg::OP_ADD: begin
				for (int i = 0; i < k; i++) begin
					prod = c.second_hash * 64'(i);
					b = (c.first_hash + prod) % sz;
					if ((b >> 6) < WORDS) filter_words[b >> 6][b[5:0]] = 1'b1;
				end
				add_total = add_total + 32'd1;
			end
			bfdh_pkg::OP_QUERY: begin
				r.maybe_present = 1'b1;
				for (int i = 0; i < k; i++) begin
					prod = c.second_hash * 64'(i);
					b = (c.first_hash + prod) % sz;
					if ((b >> 6) >= WORDS || !filter_words[b >> 6][b[5:0]])
						r.maybe_present = 1'b0;
				end
			end
			bfdh_pkg::OP_CLEAR: begin
				foreach (filter_words[j]) filter_words[j] = '0;
				add_total = '0;
			end
			default: begin
				if (c.word_index < WORDS) r.word_value = filter_words[c.word_index];
			end
		endcase
		r.insert_count = add_total;
		expected_q.push_back(r);
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		bfdh_pkg::res_t e;
		if (!arst_n) begin
			foreach (filter_words[j]) filter_words[j] = '0;
			add_total = '0;
			size_reg = bfdh_pkg::NUM_BITS_W'(bfdh_pkg::NUM_BITS_RST);
			probe_reg = bfdh_pkg::NUM_HASH_W'(bfdh_pkg::NUM_HASH_RST);
			expected_q.delete();
			errors = 0;
		end else begin
			// a transaction accepted at this edge sees the old registers
			if (cmd_valid && cmd_ready) apply_cmd(cmd);
			if (cfg_we) begin
				if (cfg_index == bfdh_pkg::CFG_NUM_BITS)
					size_reg = cfg_data[bfdh_pkg::NUM_BITS_W-1:0];
				else probe_reg = cfg_data[bfdh_pkg::NUM_HASH_W-1:0];
			end
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected res transaction %p", res);
				end else begin
					e = expected_q.pop_front();
					if (e.maybe_present !== res.maybe_present || e.word_value !== res.word_value
							|| e.insert_count !== res.insert_count) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p actual %p", e, res);
					end
				end
			end
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the double hashing bloom filter: directed then random adds,
// queries, clears and reads over several filter sizes and probe counts,
// with random stalls on both channels
// ----------------------------------------------------------------------------
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	bfdh_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	bfdh_pkg::res_t res;
	logic cfg_we = 1'b0;
	logic cfg_index = bfdh_pkg::CFG_NUM_BITS;
	logic [bfdh_pkg::CFG_W-1:0] cfg_data = '0;
	int errors, pending;
	int send_idle = 8, recv_idle = 79;
	bit recv_hold = 0;
	int quiet_cycles = 0;
	logic [63:0] key_h1 [16];
	logic [63:0] key_h2 [16];

	localparam int WATCHDOG = 200000;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bloom_filter_double_hash_core u_dut (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bfdh_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		if (recv_hold) res_ready <= 1'b0;
		else res_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_cmd(input logic [1:0] op, input logic [63:0] h1,
			input logic [63:0] h2, input logic [9:0] widx);
		@(posedge clk);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		cmd_valid <= 1'b1;
		cmd <= '{op: op, first_hash: h1, second_hash: h2, word_index: widx};
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		cmd_valid <= 1'b0;
	endtask

	task automatic write_cfg(input logic idx, input logic [bfdh_pkg::CFG_W-1:0] val);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_cmd();
		int r, s;
		r = $urandom_range(99);
		s = $urandom_range(15);
		if (r < 40)
			send_cmd(bfdh_pkg::OP_ADD, key_h1[s], key_h2[s], 10'($urandom));
		else if (r < 55)
			send_cmd(bfdh_pkg::OP_ADD, {$urandom, $urandom}, {$urandom, $urandom},
				10'($urandom));
		else if (r < 75)
			send_cmd(bfdh_pkg::OP_QUERY, key_h1[s], key_h2[s], 10'($urandom));
		else if (r < 85)
			send_cmd(bfdh_pkg::OP_QUERY, {$urandom, $urandom}, {$urandom, $urandom},
				10'($urandom));
		else if (r < 98)
			send_cmd(bfdh_pkg::OP_READ, {$urandom, $urandom}, {$urandom, $urandom},
				10'($urandom));
		else
			send_cmd(bfdh_pkg::OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom},
				10'($urandom));
	endtask

	initial begin
		int sizes [6] = '{64, 65536, 131071, 0, 1000, 4096};
		int hashes [6] = '{1, 16, 31, 0, 3, 7};
		foreach (key_h1[i]) begin
			key_h1[i] = {$urandom, $urandom};
			key_h2[i] = {$urandom, $urandom};
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		send_cmd(bfdh_pkg::OP_ADD, '1, '1, '1);
		send_cmd(bfdh_pkg::OP_QUERY, '1, '1, '0);
		send_cmd(bfdh_pkg::OP_ADD, '0, '0, '0);
		send_cmd(bfdh_pkg::OP_QUERY, '0, '0, '0);
		send_cmd(bfdh_pkg::OP_QUERY, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
			10'h155);
		send_cmd(bfdh_pkg::OP_READ, '0, '0, 10'd1023);
		send_cmd(bfdh_pkg::OP_READ, '0, '0, 10'd0);
		send_cmd(bfdh_pkg::OP_READ, '0, '0, 10'h2aa);
		send_cmd(bfdh_pkg::OP_CLEAR, '1, '1, '1);
		send_cmd(bfdh_pkg::OP_READ, '0, '0, 10'd1023);
		write_cfg(bfdh_pkg::CFG_NUM_BITS, 17'd64);
		write_cfg(bfdh_pkg::CFG_NUM_HASHES, 17'd16);
		send_cmd(bfdh_pkg::OP_ADD, 64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_ffff, '0);
		send_cmd(bfdh_pkg::OP_QUERY, 64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_ffff, '0);
		send_cmd(bfdh_pkg::OP_READ, '0, '0, '0);
		write_cfg(bfdh_pkg::CFG_NUM_BITS, 17'h1ffff);
		send_cmd(bfdh_pkg::OP_READ, '0, '0, '0);
		send_cmd(bfdh_pkg::OP_QUERY, 64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_ffff, '0);

		// long receiver hold while the sender keeps offering
		recv_hold = 1;
		fork
			repeat (6) send_cmd(bfdh_pkg::OP_ADD, {$urandom, $urandom}, {$urandom, $urandom},
				'0);
			begin
				repeat (3000) @(posedge clk);
				recv_hold = 0;
			end
		join

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin send_idle = 79; recv_idle = 8; end
			if (ph == 4) begin send_idle = 0; recv_idle = 0; end
			write_cfg(bfdh_pkg::CFG_NUM_BITS, bfdh_pkg::CFG_W'(sizes[ph]));
			write_cfg(bfdh_pkg::CFG_NUM_HASHES, bfdh_pkg::CFG_W'(hashes[ph]));
			repeat (155) random_cmd();
		end

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
rtl/bfdh_pkg.sv
rtl/bfdh_mod.sv
rtl/bloom_filter_double_hash_core.sv
test/bfdh_checker.sv
test/tb.sv
